// ----- rtl/dsrv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsrv_pkg
// Shared constants, types and the byte-wide CRC-32 step of the dual-slot
// record validator.
// ----------------------------------------------------------------------------
package dsrv_pkg;

  localparam int unsigned PAYLOAD_MAX   = 256;
  localparam int unsigned HEADER_BYTES  = 24;
  localparam int unsigned HDR_CRC_BYTES = HEADER_BYTES - 4;
  localparam int unsigned HDR_WORDS     = HEADER_BYTES / 4;

  localparam int unsigned POS_W   = 9;
  localparam int unsigned CNT_W   = POS_W + 1;
  localparam int unsigned SIZE_W  = 9;
  localparam int unsigned WIDX_W  = 3;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] MAGIC_RST   = 32'h5236_3453;
  localparam logic [15:0] VERSION_RST = 16'd1;

  localparam int unsigned PADDR_W = 3;
  localparam logic REG_MAGIC   = 1'b0;
  localparam logic REG_VERSION = 1'b1;

  localparam logic [1:0] SEL_SLOT0 = 2'd0;
  localparam logic [1:0] SEL_SLOT1 = 2'd1;
  localparam logic [1:0] SEL_NONE  = 2'd2;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_SHORT = 3'd1,
    ERR_ID    = 3'd2,
    ERR_SIZE  = 3'd3,
    ERR_HCRC  = 3'd4,
    ERR_PCRC  = 3'd5
  } err_t;

  typedef struct packed {
    err_t              err;
    logic [31:0]       gen;
    logic [31:0]       boot;
    logic [SIZE_W-1:0] size;
  } rec_verdict_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// ----- rtl/dsrv_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsrv channel interfaces
// Valid/ready channels for the record byte stream and the record verdicts.
// ----------------------------------------------------------------------------
interface dsrv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       slot;
  logic       last_byte;

  modport source (output valid, output data_byte, output slot, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input slot, input last_byte,
                output ready);
endinterface

interface dsrv_out_if;
  logic        valid;
  logic        ready;
  logic        record_ok;
  logic [2:0]  error_code;
  logic        record_slot;
  logic [31:0] record_generation;
  logic [31:0] record_boot_count;
  logic [8:0]  record_payload_size;
  logic [1:0]  chosen_slot;
  logic [31:0] chosen_generation;
  logic [31:0] chosen_boot_count;

  modport source (output valid, output record_ok, output error_code, output record_slot,
                  output record_generation, output record_boot_count,
                  output record_payload_size, output chosen_slot,
                  output chosen_generation, output chosen_boot_count, input ready);
  modport sink (input valid, input record_ok, input error_code, input record_slot,
                input record_generation, input record_boot_count,
                input record_payload_size, input chosen_slot,
                input chosen_generation, input chosen_boot_count, output ready);
endinterface

// ----- rtl/dsrv_record.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsrv_record
// Tracks one record: byte position, header capture, both CRC-32 runs, and
// the verdict when the record closes.
// ----------------------------------------------------------------------------
module dsrv_record (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  logic [7:0]               data_byte,
  input  logic                     last_byte,
  input  logic [31:0]              exp_magic,
  input  logic [15:0]              exp_version,
  output dsrv_pkg::rec_verdict_t   verdict
);

  logic [dsrv_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]                hcrc_r, hcrc_nxt;
  logic [31:0]                pcrc_r, pcrc_nxt;
  logic [31:0]                hw_r   [dsrv_pkg::HDR_WORDS];
  logic [31:0]                hw_nxt [dsrv_pkg::HDR_WORDS];

  logic [dsrv_pkg::WIDX_W-1:0] widx;
  logic [1:0]                  lane;
  logic [4:0]                  lsb;
  logic [dsrv_pkg::POS_W-1:0]  pay_off;
  logic [15:0]                 size_cur;
  logic [15:0]                 size_n;
  logic                        size_ok;
  logic [dsrv_pkg::CNT_W-1:0]  count;
  logic [dsrv_pkg::CNT_W-1:0]  need;

  always_comb begin
    hw_nxt   = hw_r;
    hcrc_nxt = hcrc_r;
    pcrc_nxt = pcrc_r;
    widx     = pos_r[4:2];
    lane     = 2'd3 - pos_r[1:0];
    lsb      = {lane, 3'b000};
    pay_off  = pos_r - dsrv_pkg::POS_W'(dsrv_pkg::HEADER_BYTES);
    size_cur = hw_r[1][15:0];
    if (pos_r < dsrv_pkg::POS_W'(dsrv_pkg::HEADER_BYTES)) begin
      hw_nxt[widx][lsb +: 8] = hw_r[widx][lsb +: 8] | data_byte;
      if (pos_r < dsrv_pkg::POS_W'(dsrv_pkg::HDR_CRC_BYTES)) begin
        hcrc_nxt = dsrv_pkg::crc32_byte(hcrc_r, data_byte);
      end
    end else if (size_cur <= 16'(dsrv_pkg::PAYLOAD_MAX) && {7'd0, pay_off} < size_cur) begin
      pcrc_nxt = dsrv_pkg::crc32_byte(pcrc_r, data_byte);
    end
  end

  always_comb begin
    count   = {1'b0, pos_r} + dsrv_pkg::CNT_W'(1);
    size_n  = hw_nxt[1][15:0];
    size_ok = size_n <= 16'(dsrv_pkg::PAYLOAD_MAX);
    need    = dsrv_pkg::CNT_W'(dsrv_pkg::HEADER_BYTES) + {1'b0, size_n[dsrv_pkg::SIZE_W-1:0]};
    verdict.gen  = hw_nxt[2];
    verdict.boot = hw_nxt[3];
    verdict.size = size_ok ? size_n[dsrv_pkg::SIZE_W-1:0] : '0;
    priority if (count < dsrv_pkg::CNT_W'(dsrv_pkg::HEADER_BYTES)) begin
      verdict.err = dsrv_pkg::ERR_SHORT;
    end else if (hw_nxt[0] != exp_magic || hw_nxt[1][31:16] != exp_version) begin
      verdict.err = dsrv_pkg::ERR_ID;
    end else if (!size_ok) begin
      verdict.err = dsrv_pkg::ERR_SIZE;
    end else if (hw_nxt[5] != ~hcrc_nxt) begin
      verdict.err = dsrv_pkg::ERR_HCRC;
    end else if (count < need) begin
      verdict.err = dsrv_pkg::ERR_SHORT;
    end else if (hw_nxt[4] != ~pcrc_nxt) begin
      verdict.err = dsrv_pkg::ERR_PCRC;
    end else begin
      verdict.err = dsrv_pkg::ERR_NONE;
    end
  end

  always_comb begin
    if (count[dsrv_pkg::CNT_W-1]) begin
      pos_nxt = dsrv_pkg::POS_MAX;
    end else begin
      pos_nxt = count[dsrv_pkg::POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      hcrc_r <= dsrv_pkg::CRC_INIT;
      pcrc_r <= dsrv_pkg::CRC_INIT;
      for (int i = 0; i < dsrv_pkg::HDR_WORDS; i++) begin
        hw_r[i] <= '0;
      end
    end else if (step) begin
      if (last_byte) begin
        pos_r  <= '0;
        hcrc_r <= dsrv_pkg::CRC_INIT;
        pcrc_r <= dsrv_pkg::CRC_INIT;
        for (int i = 0; i < dsrv_pkg::HDR_WORDS; i++) begin
          hw_r[i] <= '0;
        end
      end else begin
        pos_r  <= pos_nxt;
        hcrc_r <= hcrc_nxt;
        pcrc_r <= pcrc_nxt;
        hw_r   <= hw_nxt;
      end
    end
  end

endmodule

// ----- rtl/dual_slot_record_validator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_slot_record_validator_unit
// Validates A/B save records streamed one byte per word and selects the
// newest valid slot.
// ----------------------------------------------------------------------------
// The block takes one record byte per cycle unless a closing word waits for
// the output: each word passes an input register and then a single step of
// byte-wide CRC-32, header capture and, on the closing byte, the record checks
// and slot selection. A record's verdict is registered onto the output channel
// as its closing word leaves the input register; input keeps flowing while a
// verdict waits to be taken unless a second closing word arrives behind it.
// Bytes of a record need not carry the same slot tag; the closing byte's tag
// decides. Magic and version registers lie at byte addresses 0 and 4.
module dual_slot_record_validator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  dsrv_in_if.sink                        in_ch,
  dsrv_out_if.source                     out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dsrv_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [31:0] magic_r;
  logic [15:0] version_r;
  logic        reg_wr;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_slot_r;
  logic       s1_last_r;
  logic       s1_adv;
  logic       out_free;
  logic       close;

  dsrv_pkg::rec_verdict_t verdict;

  logic        sv_r   [2];
  logic [31:0] sg_r   [2];
  logic [31:0] sb_r   [2];
  logic        sv_nxt [2];
  logic [31:0] sg_nxt [2];
  logic [31:0] sb_nxt [2];
  logic        rec_ok;
  logic [1:0]  chosen;
  logic [31:0] cgen;
  logic [31:0] cboot;

  logic        out_valid_r;
  logic        ok_r;
  logic [2:0]  err_r;
  logic        rslot_r;
  logic [31:0] rgen_r;
  logic [31:0] rboot_r;
  logic [8:0]  rsize_r;
  logic [1:0]  cslot_r;
  logic [31:0] cgen_r;
  logic [31:0] cboot_r;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == dsrv_pkg::REG_VERSION) ? {16'd0, version_r} : magic_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= dsrv_pkg::MAGIC_RST;
      version_r <= dsrv_pkg::VERSION_RST;
    end else if (reg_wr) begin
      unique case (paddr[2])
        dsrv_pkg::REG_MAGIC:   magic_r   <= pwdata;
        dsrv_pkg::REG_VERSION: version_r <= pwdata[15:0];
        default:               magic_r   <= magic_r;
      endcase
    end
  end

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && (!s1_last_r || out_free);
  assign close       = s1_adv && s1_last_r;
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.data_byte;
      s1_slot_r <= in_ch.slot;
      s1_last_r <= in_ch.last_byte;
    end
  end

  dsrv_record u_record (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_adv),
    .data_byte   (s1_byte_r),
    .last_byte   (s1_last_r),
    .exp_magic   (magic_r),
    .exp_version (version_r),
    .verdict     (verdict)
  );

  always_comb begin
    rec_ok = verdict.err == dsrv_pkg::ERR_NONE;
    sv_nxt = sv_r;
    sg_nxt = sg_r;
    sb_nxt = sb_r;
    sv_nxt[s1_slot_r] = rec_ok;
    sg_nxt[s1_slot_r] = rec_ok ? verdict.gen : '0;
    sb_nxt[s1_slot_r] = rec_ok ? verdict.boot : '0;
    priority if (sv_nxt[0] && sv_nxt[1]) begin
      chosen = (sg_nxt[1] > sg_nxt[0]) ? dsrv_pkg::SEL_SLOT1 : dsrv_pkg::SEL_SLOT0;
    end else if (sv_nxt[0]) begin
      chosen = dsrv_pkg::SEL_SLOT0;
    end else if (sv_nxt[1]) begin
      chosen = dsrv_pkg::SEL_SLOT1;
    end else begin
      chosen = dsrv_pkg::SEL_NONE;
    end
    unique case (chosen)
      dsrv_pkg::SEL_SLOT0: begin
        cgen  = sg_nxt[0];
        cboot = sb_nxt[0];
      end
      dsrv_pkg::SEL_SLOT1: begin
        cgen  = sg_nxt[1];
        cboot = sb_nxt[1];
      end
      default: begin
        cgen  = '0;
        cboot = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        sv_r[i] <= 1'b0;
        sg_r[i] <= '0;
        sb_r[i] <= '0;
      end
    end else if (close) begin
      sv_r <= sv_nxt;
      sg_r <= sg_nxt;
      sb_r <= sb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (close) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (close) begin
      ok_r    <= rec_ok;
      err_r   <= verdict.err;
      rslot_r <= s1_slot_r;
      rgen_r  <= verdict.gen;
      rboot_r <= verdict.boot;
      rsize_r <= verdict.size;
      cslot_r <= chosen;
      cgen_r  <= cgen;
      cboot_r <= cboot;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.record_ok           = ok_r;
  assign out_ch.error_code          = err_r;
  assign out_ch.record_slot         = rslot_r;
  assign out_ch.record_generation   = rgen_r;
  assign out_ch.record_boot_count   = rboot_r;
  assign out_ch.record_payload_size = rsize_r;
  assign out_ch.chosen_slot         = cslot_r;
  assign out_ch.chosen_generation   = cgen_r;
  assign out_ch.chosen_boot_count   = cboot_r;

endmodule

// ----- rtl/dsrv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsrv_checker
// Port-level checks on the verdict channel of the record validator.
// ----------------------------------------------------------------------------
module dsrv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        record_ok,
  input logic [2:0]  error_code,
  input logic [8:0]  record_payload_size,
  input logic [1:0]  chosen_slot,
  input logic [31:0] chosen_generation,
  input logic [31:0] chosen_boot_count
);

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("verdict word dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(error_code) && $stable(chosen_slot))
    else $error("verdict word changed while stalled");

  a_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (record_ok == (error_code == dsrv_pkg::ERR_NONE)))
    else $error("record_ok disagrees with error_code");

  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && chosen_slot == dsrv_pkg::SEL_NONE |->
      chosen_generation == '0 && chosen_boot_count == '0)
    else $error("no valid slot but chosen fields are nonzero");

  a_ok_slot_chosen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && record_ok |->
      chosen_slot != dsrv_pkg::SEL_NONE &&
      record_payload_size <= 9'(dsrv_pkg::PAYLOAD_MAX))
    else $error("good record left no slot chosen or size out of range");

endmodule

bind dual_slot_record_validator_unit dsrv_checker u_dsrv_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .record_ok           (out_ch.record_ok),
  .error_code          (out_ch.error_code),
  .record_payload_size (out_ch.record_payload_size),
  .chosen_slot         (out_ch.chosen_slot),
  .chosen_generation   (out_ch.chosen_generation),
  .chosen_boot_count   (out_ch.chosen_boot_count)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the dual-slot record validator. Save records
// are built with correct or damaged headers and CRCs and streamed one byte
// per word; a local model of the validator predicts every verdict and slot
// choice, and each verdict taken from the output channel is compared field
// by field. Register writes and read-backs go through the APB-style port
// between record streams, and the traffic runs under several idle and stall
// patterns, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [31:0] RESET_MAGIC   = 32'h5236_3453;
  localparam logic [15:0] RESET_VERSION = 16'd1;
  localparam logic [dsrv_pkg::PADDR_W-1:0] ADDR_MAGIC   = {dsrv_pkg::REG_MAGIC, 2'b00};
  localparam logic [dsrv_pkg::PADDR_W-1:0] ADDR_VERSION = {dsrv_pkg::REG_VERSION, 2'b00};
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BYTES   = 40;

  typedef struct {
    logic           ok;
    dsrv_pkg::err_t err;
    logic           slot;
    logic [31:0]    gen;
    logic [31:0]    boot;
    logic [8:0]     size;
    logic [1:0]     chosen;
    logic [31:0]    cgen;
    logic [31:0]    cboot;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [dsrv_pkg::PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  dsrv_in_if  in_if ();
  dsrv_out_if out_if ();

  dual_slot_record_validator_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [31:0] cfg_magic;
  logic [15:0] cfg_version;
  logic [8:0]  rx_pos;
  logic [31:0] hdr_crc;
  logic [31:0] pay_crc;
  logic [31:0] hdr_words [6];
  logic        slot_ok [2];
  logic [31:0] slot_gen [2];
  logic [31:0] slot_boot [2];

  verdict_t   pending_verdicts [$];
  logic [7:0] rec_bytes [$];

  int errors = 0;
  int verdicts_checked = 0;
  int bytes_sent = 0;
  int code_hits [6] = '{default: 0};
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d verdicts outstanding", $time,
               cycle_count, pending_verdicts.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  function automatic void compare_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_val, act_val);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : verdict_checker
    verdict_t v;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected verdict, expected none, got slot %0d code %0d", $time,
                 out_if.record_slot, out_if.error_code);
        errors++;
      end else begin
        v = pending_verdicts.pop_front();
        compare_field("record_ok", 32'(v.ok), 32'(out_if.record_ok));
        compare_field("error_code", 32'(v.err), 32'(out_if.error_code));
        compare_field("record_slot", 32'(v.slot), 32'(out_if.record_slot));
        compare_field("record_generation", v.gen, out_if.record_generation);
        compare_field("record_boot_count", v.boot, out_if.record_boot_count);
        compare_field("record_payload_size", 32'(v.size), 32'(out_if.record_payload_size));
        compare_field("chosen_slot", 32'(v.chosen), 32'(out_if.chosen_slot));
        compare_field("chosen_generation", v.cgen, out_if.chosen_generation);
        compare_field("chosen_boot_count", v.cboot, out_if.chosen_boot_count);
        verdicts_checked++;
        code_hits[v.err]++;
      end
    end
  end

  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = {1'b0, c[31:1]};
      if (fb) begin
        c = c ^ dsrv_pkg::CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic void clear_record_state();
    rx_pos = '0;
    hdr_crc = dsrv_pkg::CRC_INIT;
    pay_crc = dsrv_pkg::CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      hdr_words[i] = '0;
    end
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic s, input logic last);
    int unsigned p;
    int unsigned cnt;
    int unsigned sz;
    verdict_t v;
    p = rx_pos;
    if (p < dsrv_pkg::HEADER_BYTES) begin
      hdr_words[p / 4] = hdr_words[p / 4] | ({24'd0, b} << (8 * (3 - (p % 4))));
      if (p < dsrv_pkg::HEADER_BYTES - 4) begin
        hdr_crc = crc_update(hdr_crc, b);
      end
    end else begin
      sz = hdr_words[1][15:0];
      if (sz <= dsrv_pkg::PAYLOAD_MAX && p - dsrv_pkg::HEADER_BYTES < sz) begin
        pay_crc = crc_update(pay_crc, b);
      end
    end
    cnt = p + 1;
    if (!last) begin
      rx_pos = (cnt > dsrv_pkg::POS_MAX) ? dsrv_pkg::POS_MAX : 9'(cnt);
      return;
    end
    sz = hdr_words[1][15:0];
    if (cnt < dsrv_pkg::HEADER_BYTES) begin
      v.err = dsrv_pkg::ERR_SHORT;
    end else if (hdr_words[0] != cfg_magic || hdr_words[1][31:16] != cfg_version) begin
      v.err = dsrv_pkg::ERR_ID;
    end else if (sz > dsrv_pkg::PAYLOAD_MAX) begin
      v.err = dsrv_pkg::ERR_SIZE;
    end else if (hdr_words[5] != ~hdr_crc) begin
      v.err = dsrv_pkg::ERR_HCRC;
    end else if (cnt < dsrv_pkg::HEADER_BYTES + sz) begin
      v.err = dsrv_pkg::ERR_SHORT;
    end else if (hdr_words[4] != ~pay_crc) begin
      v.err = dsrv_pkg::ERR_PCRC;
    end else begin
      v.err = dsrv_pkg::ERR_NONE;
    end
    v.ok = (v.err == dsrv_pkg::ERR_NONE);
    v.slot = s;
    v.gen = hdr_words[2];
    v.boot = hdr_words[3];
    v.size = (sz <= dsrv_pkg::PAYLOAD_MAX) ? 9'(sz) : 9'd0;
    slot_ok[s] = v.ok;
    slot_gen[s] = v.ok ? v.gen : 32'd0;
    slot_boot[s] = v.ok ? v.boot : 32'd0;
    if (slot_ok[0] && slot_ok[1]) begin
      v.chosen = (slot_gen[1] > slot_gen[0]) ? dsrv_pkg::SEL_SLOT1 : dsrv_pkg::SEL_SLOT0;
    end else if (slot_ok[0]) begin
      v.chosen = dsrv_pkg::SEL_SLOT0;
    end else if (slot_ok[1]) begin
      v.chosen = dsrv_pkg::SEL_SLOT1;
    end else begin
      v.chosen = dsrv_pkg::SEL_NONE;
    end
    v.cgen = (v.chosen == dsrv_pkg::SEL_NONE) ? 32'd0 : slot_gen[v.chosen[0]];
    v.cboot = (v.chosen == dsrv_pkg::SEL_NONE) ? 32'd0 : slot_boot[v.chosen[0]];
    pending_verdicts.push_back(v);
    clear_record_state();
  endtask

  task automatic send_byte(input logic [7:0] b, input logic s, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= b;
    in_if.slot <= s;
    in_if.last_byte <= last;
    @(posedge clk);
    while (!in_if.ready) begin
      @(posedge clk);
    end
    predict_byte(b, s, last);
    bytes_sent++;
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [dsrv_pkg::PADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_MAGIC) begin
      cfg_magic = data;
    end else begin
      cfg_version = data[15:0];
    end
    @(posedge clk);
  endtask

  task automatic apb_readback(input logic [dsrv_pkg::PADDR_W-1:0] addr);
    logic [31:0] rd;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_MAGIC) begin
      compare_field("prdata magic", cfg_magic, rd);
    end else begin
      compare_field("prdata version", {16'd0, cfg_version}, {16'd0, rd[15:0]});
    end
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] magic, input logic [15:0] ver);
    apb_write(ADDR_MAGIC, magic);
    apb_write(ADDR_VERSION, {16'd0, ver});
    apb_readback(ADDR_MAGIC);
    apb_readback(ADDR_VERSION);
  endtask

  task automatic build_record(input logic [31:0] magic, input logic [15:0] ver,
                              input logic [15:0] size, input logic [31:0] gen,
                              input logic [31:0] boot);
    logic [31:0] words [6];
    logic [7:0]  pay [$];
    logic [31:0] c;
    int n;
    n = (size > dsrv_pkg::PAYLOAD_MAX) ? $urandom_range(8) : size;
    for (int i = 0; i < n; i++) begin
      pay.push_back(8'($urandom_range(255)));
    end
    c = dsrv_pkg::CRC_INIT;
    for (int i = 0; i < n; i++) begin
      c = crc_update(c, pay[i]);
    end
    words[0] = magic;
    words[1] = {ver, size};
    words[2] = gen;
    words[3] = boot;
    words[4] = (size > dsrv_pkg::PAYLOAD_MAX) ? $urandom : ~c;
    c = dsrv_pkg::CRC_INIT;
    for (int i = 0; i < dsrv_pkg::HEADER_BYTES - 4; i++) begin
      c = crc_update(c, words[i / 4][8 * (3 - (i % 4)) +: 8]);
    end
    words[5] = ~c;
    rec_bytes.delete();
    for (int i = 0; i < dsrv_pkg::HEADER_BYTES; i++) begin
      rec_bytes.push_back(words[i / 4][8 * (3 - (i % 4)) +: 8]);
    end
    for (int i = 0; i < n; i++) begin
      rec_bytes.push_back(pay[i]);
    end
  endtask

  task automatic send_record(input logic s, input logic mixed);
    int last_idx;
    logic tag;
    last_idx = rec_bytes.size() - 1;
    for (int i = 0; i <= last_idx; i++) begin
      tag = (mixed && i != last_idx) ? 1'($urandom_range(1)) : s;
      send_byte(rec_bytes[i], tag, i == last_idx);
    end
  endtask

  task automatic append_noise(input int n);
    for (int i = 0; i < n; i++) begin
      rec_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic random_record();
    int kind;
    int pick;
    logic [15:0] size;
    logic [31:0] gen;
    int drop;
    kind = $urandom_range(99);
    pick = $urandom_range(99);
    if (pick < 70) begin
      size = 16'($urandom_range(12));
    end else if (pick < 85) begin
      size = 16'($urandom_range(64, 13));
    end else if (pick < 89) begin
      size = 16'($urandom_range(dsrv_pkg::PAYLOAD_MAX, dsrv_pkg::PAYLOAD_MAX - 1));
    end else if (pick < 94) begin
      size = 16'd0;
    end else begin
      size = ($urandom_range(1) == 1) ? 16'hFFFF :
             16'($urandom_range(65535, dsrv_pkg::PAYLOAD_MAX + 1));
    end
    gen = ($urandom_range(1) == 1) ? 32'($urandom_range(7)) : $urandom;
    if (kind < 55) begin
      build_record(cfg_magic, cfg_version, size, gen, $urandom);
    end else if (kind < 62) begin
      if ($urandom_range(1) == 1) begin
        build_record(cfg_magic ^ (32'd1 << $urandom_range(31)), cfg_version, size, gen,
                     $urandom);
      end else begin
        build_record(cfg_magic, cfg_version ^ (16'd1 << $urandom_range(15)), size, gen,
                     $urandom);
      end
    end else if (kind < 70) begin
      build_record(cfg_magic, cfg_version, size, gen, $urandom);
      rec_bytes[$urandom_range(dsrv_pkg::HEADER_BYTES - 1)] ^= 8'(1 << $urandom_range(7));
    end else if (kind < 78) begin
      build_record(cfg_magic, cfg_version, size, gen, $urandom);
      if (rec_bytes.size() > dsrv_pkg::HEADER_BYTES) begin
        rec_bytes[$urandom_range(rec_bytes.size() - 1, dsrv_pkg::HEADER_BYTES)] ^=
          8'(1 << $urandom_range(7));
      end else begin
        rec_bytes[$urandom_range(dsrv_pkg::HEADER_BYTES - 1)] ^= 8'(1 << $urandom_range(7));
      end
    end else if (kind < 84) begin
      build_record(cfg_magic, cfg_version, size, gen, $urandom);
      drop = $urandom_range(rec_bytes.size() - 1, 1);
      for (int i = 0; i < drop; i++) begin
        void'(rec_bytes.pop_back());
      end
    end else if (kind < 90) begin
      build_record(cfg_magic, cfg_version, size, gen, $urandom);
      append_noise($urandom_range(20, 1));
    end else if (kind < 95) begin
      rec_bytes.delete();
      append_noise($urandom_range(40, 1));
    end else begin
      build_record(cfg_magic, cfg_version,
                   16'($urandom_range(65535, dsrv_pkg::PAYLOAD_MAX + 1)), gen, $urandom);
    end
    send_record(1'($urandom_range(1)), $urandom_range(9) == 0);
  endtask

  task automatic test_register_reset();
    apb_readback(ADDR_MAGIC);
    apb_readback(ADDR_VERSION);
  endtask

  task automatic test_directed_records();
    build_record(cfg_magic, cfg_version, 16'd4, 32'd5, 32'd100);
    send_record(1'b0, 1'b0);
    build_record(cfg_magic, cfg_version, 16'd0, 32'd9, 32'd200);
    send_record(1'b1, 1'b0);
    build_record(cfg_magic, cfg_version, 16'd2, 32'd9, 32'd300);
    send_record(1'b0, 1'b0);
    rec_bytes.delete();
    append_noise(1);
    send_record(1'b1, 1'b0);
    build_record(cfg_magic, cfg_version, 16'd3, 32'hA5A5_5A5A, 32'h1234_5678);
    for (int i = 0; i < 14; i++) begin
      void'(rec_bytes.pop_back());
    end
    send_record(1'b1, 1'b0);
    build_record(~cfg_magic, cfg_version, 16'd1, 32'd1, 32'd1);
    send_record(1'b0, 1'b0);
    build_record(cfg_magic, cfg_version + 16'd1, 16'd1, 32'd2, 32'd2);
    send_record(1'b1, 1'b0);
    build_record(cfg_magic, cfg_version, 16'(dsrv_pkg::PAYLOAD_MAX + 1), 32'd3, 32'd3);
    send_record(1'b0, 1'b0);
    build_record(cfg_magic, cfg_version, 16'hFFFF, 32'd4, 32'd4);
    send_record(1'b1, 1'b0);
    build_record(cfg_magic, cfg_version, 16'd2, 32'd6, 32'd6);
    rec_bytes[dsrv_pkg::HEADER_BYTES - 4] ^= 8'h80;
    send_record(1'b0, 1'b0);
    build_record(cfg_magic, cfg_version, 16'd8, 32'd7, 32'd7);
    for (int i = 0; i < 3; i++) begin
      void'(rec_bytes.pop_back());
    end
    send_record(1'b1, 1'b0);
    build_record(cfg_magic, cfg_version, 16'd8, 32'd8, 32'd8);
    rec_bytes[dsrv_pkg::HEADER_BYTES + 7] ^= 8'h01;
    send_record(1'b0, 1'b0);
    build_record(cfg_magic, cfg_version, 16'd3, 32'd10, 32'd10);
    append_noise(5);
    send_record(1'b0, 1'b0);
    build_record(cfg_magic, cfg_version, 16'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_record(1'b1, 1'b1);
    build_record(cfg_magic, cfg_version, 16'(dsrv_pkg::PAYLOAD_MAX), 32'd0, 32'd0);
    append_noise(240);
    send_record(1'b0, 1'b0);
    build_record(cfg_magic, cfg_version, 16'(dsrv_pkg::PAYLOAD_MAX), 32'hFFFF_FFFF, 32'd77);
    send_record(1'b0, 1'b0);
    rec_bytes.delete();
    for (int i = 0; i < dsrv_pkg::HEADER_BYTES; i++) begin
      rec_bytes.push_back(8'h00);
    end
    send_record(1'b1, 1'b0);
    wait_drain();
  endtask

  task automatic test_config_settings();
    logic [31:0] magics [4];
    logic [15:0] versions [4];
    magics = '{32'd0, 32'hFFFF_FFFF, $urandom, RESET_MAGIC};
    versions = '{16'd0, 16'hFFFF, 16'($urandom_range(65535)), RESET_VERSION};
    for (int k = 0; k < 4; k++) begin
      set_config(magics[k], versions[k]);
      build_record(cfg_magic, cfg_version, 16'($urandom_range(6)), $urandom, $urandom);
      send_record(1'($urandom_range(1)), 1'b0);
      build_record(RESET_MAGIC, cfg_version, 16'd2, $urandom, $urandom);
      send_record(1'($urandom_range(1)), 1'b0);
      build_record(cfg_magic, cfg_version - 16'd1, 16'd1, $urandom, $urandom);
      send_record(1'($urandom_range(1)), 1'b0);
      wait_drain();
    end
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_req <= hold_req + 1;
    for (int i = 0; i < 80; i++) begin
      send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
    end
    for (int i = 0; i < 4; i++) begin
      build_record(cfg_magic, cfg_version, 16'($urandom_range(6)), $urandom_range(3), $urandom);
      send_record(1'($urandom_range(1)), 1'b0);
    end
    wait_drain();
  endtask

  task automatic test_random_traffic();
    int idle_pcts [4];
    int stall_pcts [4];
    int start;
    idle_pcts = '{0, 66, 0, 26};
    stall_pcts = '{0, 0, 66, 26};
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 2) begin
        set_config($urandom, 16'($urandom_range(65535)));
      end else if (ph == 3) begin
        set_config(RESET_MAGIC, RESET_VERSION);
      end
      sender_idle_pct = idle_pcts[ph];
      receiver_stall_pct = stall_pcts[ph];
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
        random_record();
      end
      wait_drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.slot = 1'b0;
    in_if.last_byte = 1'b0;
    cfg_magic = RESET_MAGIC;
    cfg_version = RESET_VERSION;
    clear_record_state();
    for (int i = 0; i < 2; i++) begin
      slot_ok[i] = 1'b0;
      slot_gen[i] = '0;
      slot_boot[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_reset();
    test_directed_records();
    test_config_settings();
    test_backpressure();
    test_random_traffic();
    wait_drain();
    $display("Run covered %0d record bytes and %0d checked verdicts, %0d mismatches.",
             bytes_sent, verdicts_checked, errors);
    $display("Verdict codes ok/short/id/size/hcrc/pcrc: %0d/%0d/%0d/%0d/%0d/%0d.",
             code_hits[0], code_hits[1], code_hits[2], code_hits[3], code_hits[4],
             code_hits[5]);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
